/* src/pvkf_pkg.sv */
// Shared types, constants and the micro-program for the 3-axis position/velocity tracker.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package pvkf_pkg;

  // Number formats
  localparam int DATA_W   = 32;              // signed Q16.16 data
  localparam int FRAC_W   = 16;
  localparam int DT_W     = 24;              // unsigned Q0.24 time step
  localparam int OPND_W   = DATA_W + 1;      // operand bus, holds unsigned registers too
  localparam int DVD_W    = DATA_W + FRAC_W; // divider dividend width
  localparam int DIV_CNT_W = $clog2(DVD_W + 1);

  localparam logic signed [DATA_W-1:0] Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] ONE_Q = DATA_W'(1) << FRAC_W;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_QN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CPP = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CPV = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CVP = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CVV = 3'd5;

  // Shared unit operations
  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_SUB   = 3'd1,
    OP_MUL16 = 3'd2,
    OP_MUL24 = 3'd3,
    OP_MUL25 = 3'd4,
    OP_MUL26 = 3'd5,
    OP_DIV   = 3'd6
  } op_t;

  // Register file addresses; position/velocity first so they map to the result slots
  localparam int RF_AW    = 5;
  localparam int RF_DEPTH = 1 << RF_AW;
  localparam int SRC_W    = RF_AW + 1;
  localparam int NUM_EST  = 6;

  localparam logic [RF_AW-1:0] R_PX  = 5'd0;
  localparam logic [RF_AW-1:0] R_PY  = 5'd1;
  localparam logic [RF_AW-1:0] R_PZ  = 5'd2;
  localparam logic [RF_AW-1:0] R_VX  = 5'd3;
  localparam logic [RF_AW-1:0] R_VY  = 5'd4;
  localparam logic [RF_AW-1:0] R_VZ  = 5'd5;
  localparam logic [RF_AW-1:0] R_PP  = 5'd6;
  localparam logic [RF_AW-1:0] R_PV  = 5'd7;
  localparam logic [RF_AW-1:0] R_VP  = 5'd8;
  localparam logic [RF_AW-1:0] R_VV  = 5'd9;
  localparam logic [RF_AW-1:0] R_DT2 = 5'd10;
  localparam logic [RF_AW-1:0] R_DT3 = 5'd11;
  localparam logic [RF_AW-1:0] R_DT4 = 5'd12;
  localparam logic [RF_AW-1:0] R_T0  = 5'd13;
  localparam logic [RF_AW-1:0] R_T1  = 5'd14;
  localparam logic [RF_AW-1:0] R_T2  = 5'd15;
  localparam logic [RF_AW-1:0] R_N00 = 5'd16;
  localparam logic [RF_AW-1:0] R_N01 = 5'd17;
  localparam logic [RF_AW-1:0] R_N10 = 5'd18;
  localparam logic [RF_AW-1:0] R_N11 = 5'd19;
  localparam logic [RF_AW-1:0] R_S   = 5'd20;
  localparam logic [RF_AW-1:0] R_G0  = 5'd21;
  localparam logic [RF_AW-1:0] R_G1  = 5'd22;

  // Operand source codes: register file (top bit clear) or external value (top bit set)
  localparam logic [SRC_W-1:0] S_PX  = {1'b0, R_PX};
  localparam logic [SRC_W-1:0] S_PY  = {1'b0, R_PY};
  localparam logic [SRC_W-1:0] S_PZ  = {1'b0, R_PZ};
  localparam logic [SRC_W-1:0] S_VX  = {1'b0, R_VX};
  localparam logic [SRC_W-1:0] S_VY  = {1'b0, R_VY};
  localparam logic [SRC_W-1:0] S_VZ  = {1'b0, R_VZ};
  localparam logic [SRC_W-1:0] S_PP  = {1'b0, R_PP};
  localparam logic [SRC_W-1:0] S_PV  = {1'b0, R_PV};
  localparam logic [SRC_W-1:0] S_VP  = {1'b0, R_VP};
  localparam logic [SRC_W-1:0] S_VV  = {1'b0, R_VV};
  localparam logic [SRC_W-1:0] S_DT2 = {1'b0, R_DT2};
  localparam logic [SRC_W-1:0] S_DT3 = {1'b0, R_DT3};
  localparam logic [SRC_W-1:0] S_DT4 = {1'b0, R_DT4};
  localparam logic [SRC_W-1:0] S_T0  = {1'b0, R_T0};
  localparam logic [SRC_W-1:0] S_T1  = {1'b0, R_T1};
  localparam logic [SRC_W-1:0] S_N00 = {1'b0, R_N00};
  localparam logic [SRC_W-1:0] S_N01 = {1'b0, R_N01};
  localparam logic [SRC_W-1:0] S_N10 = {1'b0, R_N10};
  localparam logic [SRC_W-1:0] S_N11 = {1'b0, R_N11};
  localparam logic [SRC_W-1:0] S_S   = {1'b0, R_S};
  localparam logic [SRC_W-1:0] S_G0  = {1'b0, R_G0};
  localparam logic [SRC_W-1:0] S_G1  = {1'b0, R_G1};

  localparam logic [SRC_W-1:0] X_MX   = 6'd32;  // measured or initial position
  localparam logic [SRC_W-1:0] X_MY   = 6'd33;
  localparam logic [SRC_W-1:0] X_MZ   = 6'd34;
  localparam logic [SRC_W-1:0] X_VX   = 6'd35;  // initial velocity
  localparam logic [SRC_W-1:0] X_VY   = 6'd36;
  localparam logic [SRC_W-1:0] X_VZ   = 6'd37;
  localparam logic [SRC_W-1:0] X_DT   = 6'd38;
  localparam logic [SRC_W-1:0] X_QN   = 6'd39;
  localparam logic [SRC_W-1:0] X_RN   = 6'd40;
  localparam logic [SRC_W-1:0] X_CPP  = 6'd41;
  localparam logic [SRC_W-1:0] X_CPV  = 6'd42;
  localparam logic [SRC_W-1:0] X_CVP  = 6'd43;
  localparam logic [SRC_W-1:0] X_CVV  = 6'd44;
  localparam logic [SRC_W-1:0] X_ONE  = 6'd45;
  localparam logic [SRC_W-1:0] X_ZERO = 6'd46;

  // One micro-instruction
  typedef struct packed {
    op_t              op;
    logic [SRC_W-1:0] a;
    logic [SRC_W-1:0] b;
    logic [RF_AW-1:0] dst;
    logic             last;
  } uop_t;

  localparam int PC_W = 6;
  localparam logic [PC_W-1:0] PC_UPDATE = 6'd0;
  localparam logic [PC_W-1:0] PC_INIT   = 6'd49;

  function automatic uop_t mk(input op_t op, input logic [SRC_W-1:0] a,
                              input logic [SRC_W-1:0] b, input logic [RF_AW-1:0] dst,
                              input logic last);
    uop_t u;
    u.op   = op;
    u.a    = a;
    u.b    = b;
    u.dst  = dst;
    u.last = last;
    return u;
  endfunction

  // Micro-program: measurement update from PC_UPDATE, init from PC_INIT
  function automatic uop_t prog(input logic [PC_W-1:0] pc);
    uop_t u;
    case (pc)
      // powers of dt
      6'd0:  u = mk(OP_MUL24, X_DT,  X_DT,  R_DT2, 1'b0);
      6'd1:  u = mk(OP_MUL24, S_DT2, X_DT,  R_DT3, 1'b0);
      6'd2:  u = mk(OP_MUL24, S_DT3, X_DT,  R_DT4, 1'b0);
      // predicted pp
      6'd3:  u = mk(OP_ADD,   S_PV,  S_VP,  R_T0,  1'b0);
      6'd4:  u = mk(OP_MUL24, S_T0,  X_DT,  R_T0,  1'b0);
      6'd5:  u = mk(OP_ADD,   S_PP,  S_T0,  R_N00, 1'b0);
      6'd6:  u = mk(OP_MUL24, S_VV,  S_DT2, R_T0,  1'b0);
      6'd7:  u = mk(OP_ADD,   S_N00, S_T0,  R_N00, 1'b0);
      6'd8:  u = mk(OP_MUL26, X_QN,  S_DT4, R_T0,  1'b0);
      6'd9:  u = mk(OP_ADD,   S_N00, S_T0,  R_N00, 1'b0);
      // predicted pv, vp, vv
      6'd10: u = mk(OP_MUL24, S_VV,  X_DT,  R_T1,  1'b0);
      6'd11: u = mk(OP_MUL25, X_QN,  S_DT3, R_T0,  1'b0);
      6'd12: u = mk(OP_ADD,   S_PV,  S_T1,  R_N01, 1'b0);
      6'd13: u = mk(OP_ADD,   S_N01, S_T0,  R_N01, 1'b0);
      6'd14: u = mk(OP_ADD,   S_VP,  S_T1,  R_N10, 1'b0);
      6'd15: u = mk(OP_ADD,   S_N10, S_T0,  R_N10, 1'b0);
      6'd16: u = mk(OP_MUL24, X_QN,  S_DT2, R_T0,  1'b0);
      6'd17: u = mk(OP_ADD,   S_VV,  S_T0,  R_N11, 1'b0);
      // innovation variance and gains
      6'd18: u = mk(OP_ADD,   S_N00, X_RN,  R_S,   1'b0);
      6'd19: u = mk(OP_DIV,   S_N00, S_S,   R_G0,  1'b0);
      6'd20: u = mk(OP_DIV,   S_N10, S_S,   R_G1,  1'b0);
      // x axis
      6'd21: u = mk(OP_MUL24, S_VX,  X_DT,  R_T0,  1'b0);
      6'd22: u = mk(OP_ADD,   S_PX,  S_T0,  R_T0,  1'b0);
      6'd23: u = mk(OP_SUB,   X_MX,  S_T0,  R_T1,  1'b0);
      6'd24: u = mk(OP_MUL16, S_T1,  S_G0,  R_T2,  1'b0);
      6'd25: u = mk(OP_ADD,   S_T0,  {1'b0, R_T2}, R_PX, 1'b0);
      6'd26: u = mk(OP_MUL16, S_T1,  S_G1,  R_T2,  1'b0);
      6'd27: u = mk(OP_ADD,   S_VX,  {1'b0, R_T2}, R_VX, 1'b0);
      // y axis
      6'd28: u = mk(OP_MUL24, S_VY,  X_DT,  R_T0,  1'b0);
      6'd29: u = mk(OP_ADD,   S_PY,  S_T0,  R_T0,  1'b0);
      6'd30: u = mk(OP_SUB,   X_MY,  S_T0,  R_T1,  1'b0);
      6'd31: u = mk(OP_MUL16, S_T1,  S_G0,  R_T2,  1'b0);
      6'd32: u = mk(OP_ADD,   S_T0,  {1'b0, R_T2}, R_PY, 1'b0);
      6'd33: u = mk(OP_MUL16, S_T1,  S_G1,  R_T2,  1'b0);
      6'd34: u = mk(OP_ADD,   S_VY,  {1'b0, R_T2}, R_VY, 1'b0);
      // z axis
      6'd35: u = mk(OP_MUL24, S_VZ,  X_DT,  R_T0,  1'b0);
      6'd36: u = mk(OP_ADD,   S_PZ,  S_T0,  R_T0,  1'b0);
      6'd37: u = mk(OP_SUB,   X_MZ,  S_T0,  R_T1,  1'b0);
      6'd38: u = mk(OP_MUL16, S_T1,  S_G0,  R_T2,  1'b0);
      6'd39: u = mk(OP_ADD,   S_T0,  {1'b0, R_T2}, R_PZ, 1'b0);
      6'd40: u = mk(OP_MUL16, S_T1,  S_G1,  R_T2,  1'b0);
      6'd41: u = mk(OP_ADD,   S_VZ,  {1'b0, R_T2}, R_VZ, 1'b0);
      // covariance correction
      6'd42: u = mk(OP_SUB,   X_ONE, S_G0,  R_T0,  1'b0);
      6'd43: u = mk(OP_MUL16, S_T0,  S_N00, R_PP,  1'b0);
      6'd44: u = mk(OP_MUL16, S_T0,  S_N01, R_PV,  1'b0);
      6'd45: u = mk(OP_MUL16, S_G1,  S_N00, R_T1,  1'b0);
      6'd46: u = mk(OP_SUB,   S_N10, S_T1,  R_VP,  1'b0);
      6'd47: u = mk(OP_MUL16, S_G1,  S_N01, R_T1,  1'b0);
      6'd48: u = mk(OP_SUB,   S_N11, S_T1,  R_VV,  1'b1);
      // init: load state from the item and covariance from the registers
      6'd49: u = mk(OP_ADD,   X_MX,  X_ZERO, R_PX, 1'b0);
      6'd50: u = mk(OP_ADD,   X_MY,  X_ZERO, R_PY, 1'b0);
      6'd51: u = mk(OP_ADD,   X_MZ,  X_ZERO, R_PZ, 1'b0);
      6'd52: u = mk(OP_ADD,   X_VX,  X_ZERO, R_VX, 1'b0);
      6'd53: u = mk(OP_ADD,   X_VY,  X_ZERO, R_VY, 1'b0);
      6'd54: u = mk(OP_ADD,   X_VZ,  X_ZERO, R_VZ, 1'b0);
      6'd55: u = mk(OP_ADD,   X_CPP, X_ZERO, R_PP, 1'b0);
      6'd56: u = mk(OP_ADD,   X_CPV, X_ZERO, R_PV, 1'b0);
      6'd57: u = mk(OP_ADD,   X_CVP, X_ZERO, R_VP, 1'b0);
      6'd58: u = mk(OP_ADD,   X_CVV, X_ZERO, R_VV, 1'b1);
      default: u = mk(OP_ADD, X_ZERO, X_ZERO, R_T0, 1'b1);
    endcase
    return u;
  endfunction

endpackage

`default_nettype wire

/* src/pos_vel_kalman_filter_3axis_core.sv */
// An update runs the micro-program from PC_UPDATE, fetching and executing each micro-op in turn
// and waiting on the divider for each gain divide; a zero innovation variance skips its iteration.
// An init runs the micro-program from PC_INIT. The core takes one item at a time.
// The next item is taken once the result is in the output register, which holds it meanwhile.
// Reset (synchronous, rst_n low) clears the configuration registers, state and covariance to zero.
// Depends on pvkf_pkg, pvkf_alu and pvkf_div.
`default_nettype none

module pos_vel_kalman_filter_3axis_core (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [pvkf_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [pvkf_pkg::DATA_W-1:0]             cfg_data,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic                                    in_cmd,
  input  logic signed [pvkf_pkg::DATA_W-1:0]      in_pos_x,
  input  logic signed [pvkf_pkg::DATA_W-1:0]      in_pos_y,
  input  logic signed [pvkf_pkg::DATA_W-1:0]      in_pos_z,
  input  logic signed [pvkf_pkg::DATA_W-1:0]      in_vel_x,
  input  logic signed [pvkf_pkg::DATA_W-1:0]      in_vel_y,
  input  logic signed [pvkf_pkg::DATA_W-1:0]      in_vel_z,
  input  logic [pvkf_pkg::DT_W-1:0]               in_time_step,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [pvkf_pkg::DATA_W-1:0]      out_est_pos_x,
  output logic signed [pvkf_pkg::DATA_W-1:0]      out_est_pos_y,
  output logic signed [pvkf_pkg::DATA_W-1:0]      out_est_pos_z,
  output logic signed [pvkf_pkg::DATA_W-1:0]      out_est_vel_x,
  output logic signed [pvkf_pkg::DATA_W-1:0]      out_est_vel_y,
  output logic signed [pvkf_pkg::DATA_W-1:0]      out_est_vel_z
);
  import pvkf_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_FETCH = 5'b00010,
    ST_EXEC  = 5'b00100,
    ST_DIVW  = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  state_t                    state_r, state_nxt;
  logic [PC_W-1:0]           pc_r, pc_nxt;
  uop_t                      uop;

  // configuration registers
  logic [DATA_W-1:0]         qn_r, rn_r;
  logic signed [DATA_W-1:0]  cpp_r, cpv_r, cvp_r, cvv_r;

  // captured item
  logic signed [DATA_W-1:0]  meas_r [3];
  logic signed [DATA_W-1:0]  ivel_r [3];
  logic [DT_W-1:0]           dt_r;

  // register file with valid bits standing in for the reset to zero
  logic [DATA_W-1:0]         rf_mem [RF_DEPTH];
  logic [RF_DEPTH-1:0]       rf_vld_r;
  logic [DATA_W-1:0]         rd_a_r, rd_b_r;
  logic                      rd_a_vld_r, rd_b_vld_r;
  logic                      rf_we;
  logic [RF_AW-1:0]          rf_wa;
  logic signed [DATA_W-1:0]  rf_wd;

  logic signed [OPND_W-1:0]  opa, opb;
  logic signed [DATA_W-1:0]  alu_y, div_q;
  logic                      div_start, div_done;

  // latest position/velocity and the output register
  logic signed [DATA_W-1:0]  est_r [NUM_EST];
  logic                      out_valid_r;
  logic signed [DATA_W-1:0]  out_r [NUM_EST];

  // external operand values
  function automatic logic signed [OPND_W-1:0] ext_val(input logic [SRC_W-1:0] code);
    logic signed [OPND_W-1:0] v;
    case (code)
      X_MX:    v = OPND_W'(meas_r[0]);
      X_MY:    v = OPND_W'(meas_r[1]);
      X_MZ:    v = OPND_W'(meas_r[2]);
      X_VX:    v = OPND_W'(ivel_r[0]);
      X_VY:    v = OPND_W'(ivel_r[1]);
      X_VZ:    v = OPND_W'(ivel_r[2]);
      X_DT:    v = OPND_W'({1'b0, dt_r});
      X_QN:    v = {1'b0, qn_r};
      X_RN:    v = {1'b0, rn_r};
      X_CPP:   v = OPND_W'(cpp_r);
      X_CPV:   v = OPND_W'(cpv_r);
      X_CVP:   v = OPND_W'(cvp_r);
      X_CVV:   v = OPND_W'(cvv_r);
      X_ONE:   v = OPND_W'(ONE_Q);
      default: v = '0;
    endcase
    return v;
  endfunction

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == ST_IDLE);
  assign uop       = prog(pc_r);

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qn_r  <= '0;
      rn_r  <= '0;
      cpp_r <= '0;
      cpv_r <= '0;
      cvp_r <= '0;
      cvv_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_QN:  qn_r  <= cfg_data;
        CFG_RN:  rn_r  <= cfg_data;
        CFG_CPP: cpp_r <= cfg_data;
        CFG_CPV: cpv_r <= cfg_data;
        CFG_CVP: cvp_r <= cfg_data;
        CFG_CVV: cvv_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // capture the item on transfer
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      meas_r[0] <= in_pos_x;
      meas_r[1] <= in_pos_y;
      meas_r[2] <= in_pos_z;
      ivel_r[0] <= in_vel_x;
      ivel_r[1] <= in_vel_y;
      ivel_r[2] <= in_vel_z;
      dt_r      <= in_time_step;
    end
  end

  // operand select
  always_comb begin
    opa = uop.a[SRC_W-1] ? ext_val(uop.a)
                         : OPND_W'(signed'(rd_a_vld_r ? rd_a_r : '0));
    opb = uop.b[SRC_W-1] ? ext_val(uop.b)
                         : OPND_W'(signed'(rd_b_vld_r ? rd_b_r : '0));
  end

  pvkf_alu u_alu (
    .op (uop.op),
    .a  (opa),
    .b  (opb),
    .y  (alu_y)
  );

  pvkf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .n     (opa[DATA_W-1:0]),
    .d     (opb[DATA_W-1:0]),
    .done  (div_done),
    .q     (div_q)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    pc_nxt    = pc_r;
    rf_we     = 1'b0;
    rf_wa     = uop.dst;
    rf_wd     = alu_y;
    div_start = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          pc_nxt    = in_cmd ? PC_INIT : PC_UPDATE;
          state_nxt = ST_FETCH;
        end
      end
      ST_FETCH: state_nxt = ST_EXEC;
      ST_EXEC: begin
        if (uop.op == OP_DIV) begin
          div_start = 1'b1;
          state_nxt = ST_DIVW;
        end else begin
          rf_we     = 1'b1;
          pc_nxt    = pc_r + 1'b1;
          state_nxt = uop.last ? ST_DONE : ST_FETCH;
        end
      end
      ST_DIVW: begin
        rf_wd = div_q;
        if (div_done) begin
          rf_we     = 1'b1;
          pc_nxt    = pc_r + 1'b1;
          state_nxt = uop.last ? ST_DONE : ST_FETCH;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pc_r    <= '0;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
    end
  end

  // register file: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (rf_we) rf_mem[rf_wa] <= rf_wd;
    rd_a_r <= rf_mem[uop.a[RF_AW-1:0]];
    rd_b_r <= rf_mem[uop.b[RF_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rf_vld_r   <= '0;
      rd_a_vld_r <= 1'b0;
      rd_b_vld_r <= 1'b0;
    end else begin
      if (rf_we) rf_vld_r[rf_wa] <= 1'b1;
      rd_a_vld_r <= rf_vld_r[uop.a[RF_AW-1:0]];
      rd_b_vld_r <= rf_vld_r[uop.b[RF_AW-1:0]];
    end
  end

  // track position/velocity writes for the result
  always_ff @(posedge clk) begin
    if (rf_we && rf_wa < RF_AW'(NUM_EST)) est_r[rf_wa[2:0]] <= rf_wd;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_DONE && (!out_valid_r || out_ready)) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && (!out_valid_r || out_ready)) out_r <= est_r;
  end

  assign out_valid     = out_valid_r;
  assign out_est_pos_x = out_r[0];
  assign out_est_pos_y = out_r[1];
  assign out_est_pos_z = out_r[2];
  assign out_est_vel_x = out_r[3];
  assign out_est_vel_y = out_r[4];
  assign out_est_vel_z = out_r[5];

endmodule

`default_nettype wire

/* src/pvkf_alu.sv */
// Shared arithmetic unit: saturating add/subtract and multiply with floor shift.
// Depends on pvkf_pkg.
`default_nettype none

module pvkf_alu (
  input  pvkf_pkg::op_t                          op,
  input  logic signed [pvkf_pkg::OPND_W-1:0]     a,
  input  logic signed [pvkf_pkg::OPND_W-1:0]     b,
  output logic signed [pvkf_pkg::DATA_W-1:0]     y
);
  import pvkf_pkg::*;

  localparam int PROD_W = 2 * OPND_W;

  logic signed [OPND_W:0]   sum;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] res;

  // Clamp a wide signed value to the data range
  function automatic logic signed [DATA_W-1:0] sat(input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W-1:0] hi;
    hi = v >>> (DATA_W - 1);
    if (hi == '0 || hi == '1) return v[DATA_W-1:0];
    else if (v[PROD_W-1]) return Q_MIN;
    else return Q_MAX;
  endfunction

  always_comb begin
    sum  = (op == OP_SUB) ? ((OPND_W+1)'(a) - (OPND_W+1)'(b))
                          : ((OPND_W+1)'(a) + (OPND_W+1)'(b));
    prod = PROD_W'(a) * PROD_W'(b);
    // floor shift by the product's fraction bits
    case (op)
      OP_MUL16: res = prod >>> FRAC_W;
      OP_MUL24: res = prod >>> DT_W;
      OP_MUL25: res = prod >>> (DT_W + 1);
      OP_MUL26: res = prod >>> (DT_W + 2);
      default:  res = PROD_W'(sum);
    endcase
    y = sat(res);
  end

endmodule

`default_nettype wire

/* src/pvkf_div.sv */
// Iterative restoring divider: (n << FRAC_W) / d, truncated toward zero, saturated.
// One quotient bit per cycle; a zero divisor returns one. Depends on pvkf_pkg.
`default_nettype none

module pvkf_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [pvkf_pkg::DATA_W-1:0]  n,
  input  logic signed [pvkf_pkg::DATA_W-1:0]  d,
  output logic                                done,
  output logic signed [pvkf_pkg::DATA_W-1:0]  q
);
  import pvkf_pkg::*;

  localparam logic [DIV_CNT_W-1:0] LAST_CNT = DIV_CNT_W'(DVD_W - 1);
  localparam logic [DVD_W-1:0]     LIM_NEG  = DVD_W'(1) << (DATA_W - 1);
  localparam logic [DVD_W-1:0]     LIM_POS  = LIM_NEG - DVD_W'(1);

  logic                 busy_r, done_r, zero_r, neg_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DVD_W-1:0]     dvd_r, quo_r;
  logic [DATA_W-1:0]    rem_r, ud_r;
  logic [DATA_W-1:0]    mn, md, rem_nxt;
  logic [DATA_W:0]      rem_t;
  logic                 ge;

  // operand magnitudes and one trial subtract
  always_comb begin
    mn      = n[DATA_W-1] ? (~n + 1'b1) : n;
    md      = d[DATA_W-1] ? (~d + 1'b1) : d;
    rem_t   = {rem_r, dvd_r[DVD_W-1]};
    ge      = rem_t >= {1'b0, ud_r};
    rem_nxt = ge ? DATA_W'(rem_t - {1'b0, ud_r}) : rem_t[DATA_W-1:0];
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= (d != '0);
        done_r <= (d == '0);
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST_CNT) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      zero_r <= (d == '0);
      neg_r  <= n[DATA_W-1] ^ d[DATA_W-1];
      dvd_r  <= {mn, {FRAC_W{1'b0}}};
      ud_r   <= md;
      rem_r  <= '0;
      quo_r  <= '0;
    end else if (busy_r) begin
      dvd_r <= dvd_r << 1;
      rem_r <= rem_nxt;
      quo_r <= {quo_r[DVD_W-2:0], ge};
    end
  end

  // sign and saturation of the result
  always_comb begin
    if (zero_r)                q = ONE_Q;
    else if (neg_r && quo_r > LIM_NEG) q = Q_MIN;
    else if (neg_r)            q = DATA_W'(~quo_r + 1'b1);
    else if (quo_r > LIM_POS)  q = Q_MAX;
    else                       q = quo_r[DATA_W-1:0];
  end

  assign done = done_r;

endmodule

`default_nettype wire

/* dv/pos_vel_kalman_filter_3axis_core_tb.sv */
// Self-checking testbench for the 3-axis position/velocity tracker core.
// Depends on pvkf_pkg and the core RTL; a scoreboard class predicts each result.
`timescale 1ns / 1ps

module pos_vel_kalman_filter_3axis_core_tb;
  import pvkf_pkg::*;

  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_INIT   = 1'b1;
  localparam int   SETTLE_CYC = 250;   // covers one update plus margin
  localparam int   ITEMS_PER_PHASE = 170;
  localparam int   NUM_PHASES = 5;

  typedef struct packed {
    logic                     cmd;
    logic signed [DATA_W-1:0] px, py, pz, vx, vy, vz;
    logic [DT_W-1:0]          dt;
  } meas_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] px, py, pz, vx, vy, vz;
  } est_t;

  // Tracker predictor and queue of expected estimates
  class kf_scoreboard;
    longint pos[3], vel[3], cov[4];
    longint reg_q, reg_r, reg_cov[4];
    est_t   est_q[$];
    int     errors, matched, n_init, n_update, n_zero_var;

    function void clear();
      foreach (pos[i]) begin pos[i] = 0; vel[i] = 0; end
      foreach (cov[i]) begin cov[i] = 0; reg_cov[i] = 0; end
      reg_q = 0;
      reg_r = 0;
    endfunction

    function longint sat(longint x);
      if (x > longint'(Q_MAX)) return longint'(Q_MAX);
      if (x < longint'(Q_MIN)) return longint'(Q_MIN);
      return x;
    endfunction

    // floored product shift, wide enough for every operand here
    function longint mul_floor(longint a, longint b, int sh);
      logic signed [127:0] wa, wb, p;
      wa = 128'(a);
      wb = 128'(b);
      p = (wa * wb) >>> sh;
      return longint'(p);
    endfunction

    function longint mulq(longint a, longint b, int sh);
      return sat(mul_floor(a, b, sh));
    endfunction

    // Q16.16 quotient, truncated toward zero
    function longint divq(longint n, longint d);
      logic signed [127:0] wn, wd, q;
      wn = 128'(n);
      wd = 128'(d);
      q = (wn <<< FRAC_W) / wd;
      if (q > 128'sd2147483647) return longint'(Q_MAX);
      if (q < -128'sd2147483648) return longint'(Q_MIN);
      return longint'(q);
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] v);
      case (idx)
        CFG_QN:  reg_q = longint'({32'b0, v});
        CFG_RN:  reg_r = longint'({32'b0, v});
        CFG_CPP: reg_cov[0] = longint'($signed(v));
        CFG_CPV: reg_cov[1] = longint'($signed(v));
        CFG_CVP: reg_cov[2] = longint'($signed(v));
        CFG_CVV: reg_cov[3] = longint'($signed(v));
        default: ;
      endcase
    endfunction

    function void note_input(meas_t m);
      longint meas[3], ivel[3];
      longint dt, dt2, dt3, dt4, one, n00, n01, n10, n11, s, g0, g1, pred, inn;
      est_t e;
      meas[0] = longint'(m.px); meas[1] = longint'(m.py); meas[2] = longint'(m.pz);
      ivel[0] = longint'(m.vx); ivel[1] = longint'(m.vy); ivel[2] = longint'(m.vz);
      one = longint'(ONE_Q);
      if (m.cmd == CMD_INIT) begin
        n_init++;
        foreach (pos[i]) begin pos[i] = meas[i]; vel[i] = ivel[i]; end
        foreach (cov[i]) cov[i] = reg_cov[i];
      end else begin
        n_update++;
        dt  = longint'({40'b0, m.dt});
        dt2 = mul_floor(dt, dt, DT_W);
        dt3 = mul_floor(dt2, dt, DT_W);
        dt4 = mul_floor(dt3, dt, DT_W);
        // covariance prediction
        n00 = sat(cov[0] + mulq(sat(cov[1] + cov[2]), dt, DT_W));
        n00 = sat(n00 + mulq(cov[3], dt2, DT_W));
        n00 = sat(n00 + mulq(reg_q, dt4, DT_W + 2));
        n01 = sat(sat(cov[1] + mulq(cov[3], dt, DT_W)) + mulq(reg_q, dt3, DT_W + 1));
        n10 = sat(sat(cov[2] + mulq(cov[3], dt, DT_W)) + mulq(reg_q, dt3, DT_W + 1));
        n11 = sat(cov[3] + mulq(reg_q, dt2, DT_W));
        s = sat(n00 + reg_r);
        // zero innovation variance forces both gains to one
        if (s == 0) begin
          n_zero_var++;
          g0 = one;
          g1 = one;
        end else begin
          g0 = divq(n00, s);
          g1 = divq(n10, s);
        end
        foreach (pos[i]) begin
          pred = sat(pos[i] + mulq(vel[i], dt, DT_W));
          inn = sat(meas[i] - pred);
          pos[i] = sat(pred + mulq(inn, g0, FRAC_W));
          vel[i] = sat(vel[i] + mulq(inn, g1, FRAC_W));
        end
        cov[0] = mulq(sat(one - g0), n00, FRAC_W);
        cov[1] = mulq(sat(one - g0), n01, FRAC_W);
        cov[2] = sat(n10 - mulq(g1, n00, FRAC_W));
        cov[3] = sat(n11 - mulq(g1, n01, FRAC_W));
      end
      e.px = DATA_W'(pos[0]); e.py = DATA_W'(pos[1]); e.pz = DATA_W'(pos[2]);
      e.vx = DATA_W'(vel[0]); e.vy = DATA_W'(vel[1]); e.vz = DATA_W'(vel[2]);
      est_q.push_back(e);
    endfunction

    function void cmp(string name, logic signed [DATA_W-1:0] exp_v,
                      logic signed [DATA_W-1:0] act_v);
      if (exp_v !== act_v) begin
        $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(est_t got);
      est_t e;
      if (est_q.size() == 0) begin
        $error("result transfer with no estimate pending");
        errors++;
        return;
      end
      e = est_q.pop_front();
      matched++;
      cmp("est_pos_x", e.px, got.px);
      cmp("est_pos_y", e.py, got.py);
      cmp("est_pos_z", e.pz, got.pz);
      cmp("est_vel_x", e.vx, got.vx);
      cmp("est_vel_y", e.vy, got.vy);
      cmp("est_vel_z", e.vz, got.vz);
    endfunction
  endclass

  logic                     clk, rst_n;
  logic                     cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [DATA_W-1:0]        cfg_data;
  logic                     in_valid, in_ready, in_cmd;
  logic signed [DATA_W-1:0] in_pos_x, in_pos_y, in_pos_z, in_vel_x, in_vel_y, in_vel_z;
  logic [DT_W-1:0]          in_time_step;
  logic                     out_valid, out_ready;
  logic signed [DATA_W-1:0] out_est_pos_x, out_est_pos_y, out_est_pos_z;
  logic signed [DATA_W-1:0] out_est_vel_x, out_est_vel_y, out_est_vel_z;

  kf_scoreboard sb = new();
  bit steady;      // phase without input gaps; result ready still drops now and then
  int stall_left;

  pos_vel_kalman_filter_3axis_core uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_cmd(in_cmd),
    .in_pos_x(in_pos_x), .in_pos_y(in_pos_y), .in_pos_z(in_pos_z),
    .in_vel_x(in_vel_x), .in_vel_y(in_vel_y), .in_vel_z(in_vel_z),
    .in_time_step(in_time_step),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_est_pos_x(out_est_pos_x), .out_est_pos_y(out_est_pos_y),
    .out_est_pos_z(out_est_pos_z), .out_est_vel_x(out_est_vel_x),
    .out_est_vel_y(out_est_vel_y), .out_est_vel_z(out_est_vel_z)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(20, 150);
  endfunction

  // signed value of random magnitude, full range now and then
  function automatic logic [DATA_W-1:0] rnd_val();
    int r;
    logic [DATA_W-1:0] v;
    r = $urandom_range(0, 15);
    if (r == 0) return Q_MAX;
    if (r == 1) return Q_MIN;
    if (r < 5) return $urandom();
    v = $urandom() >> $urandom_range(4, 28);
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  function automatic logic [DT_W-1:0] rnd_dt();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r < 6) return DT_W'($urandom());
    return DT_W'($urandom_range(1, 1 << 18));   // small steps, up to 1/64 in Q0.24
  endfunction

  // result side: sample the transfer, then choose the next ready level
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && out_ready)
        sb.check_result('{out_est_pos_x, out_est_pos_y, out_est_pos_z,
                          out_est_vel_x, out_est_vel_y, out_est_vel_z});
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ready <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        stall_left <= pick_gap();
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, v);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_item(meas_t m);
    int gap;
    in_valid     <= 1'b1;
    in_cmd       <= m.cmd;
    in_pos_x     <= m.px;
    in_pos_y     <= m.py;
    in_pos_z     <= m.pz;
    in_vel_x     <= m.vx;
    in_vel_y     <= m.vy;
    in_vel_z     <= m.vz;
    in_time_step <= m.dt;
    do @(posedge clk); while (!in_ready);
    sb.note_input(m);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.est_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic load_regs(logic [DATA_W-1:0] q, logic [DATA_W-1:0] r,
                           logic [DATA_W-1:0] cpp, logic [DATA_W-1:0] cpv,
                           logic [DATA_W-1:0] cvp, logic [DATA_W-1:0] cvv);
    write_cfg(CFG_QN, q);
    write_cfg(CFG_RN, r);
    write_cfg(CFG_CPP, cpp);
    write_cfg(CFG_CPV, cpv);
    write_cfg(CFG_CVP, cvp);
    write_cfg(CFG_CVV, cvv);
  endtask

  // field extremes, both commands, zero and full time step
  task automatic directed_items();
    send_item('{CMD_UPDATE, Q_MAX, Q_MIN, 32'sd0, Q_MAX, Q_MAX, Q_MAX, '1});
    send_item('{CMD_INIT, Q_MAX, Q_MIN, 32'sd65536, Q_MIN, Q_MAX, -32'sd65536, '1});
    send_item('{CMD_UPDATE, Q_MIN, Q_MAX, 32'sd0, Q_MAX, Q_MIN, Q_MAX, '0});
    send_item('{CMD_UPDATE, Q_MAX, Q_MAX, Q_MIN, 32'sd0, 32'sd0, 32'sd0, '1});
    send_item('{CMD_INIT, 32'sd0, 32'sd0, 32'sd0, Q_MAX, Q_MIN, Q_MAX, '0});
    send_item('{CMD_UPDATE, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, '1});
    send_item('{CMD_UPDATE, 32'sd1, -32'sd1, 32'sd65536, 32'sd0, 32'sd0, 32'sd0, 24'd1});
    send_item('{CMD_UPDATE, Q_MAX, Q_MAX, Q_MAX, 32'sd0, 32'sd0, 32'sd0, 24'h800000});
    send_item('{CMD_INIT, Q_MIN, Q_MAX, Q_MIN, Q_MIN, Q_MAX, Q_MIN, 24'h555555});
    send_item('{CMD_UPDATE, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, '1});
    send_item('{CMD_UPDATE, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, '1});
  endtask

  initial begin
    #20_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    meas_t m;
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_cmd = CMD_UPDATE;
    in_pos_x = '0; in_pos_y = '0; in_pos_z = '0;
    in_vel_x = '0; in_vel_y = '0; in_vel_z = '0;
    in_time_step = '0;
    steady = 1'b0;
    sb.clear();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      steady = (ph == 2);
      case (ph)
        // all zero: innovation variance stays zero, gains forced to one
        0: load_regs('0, '0, '0, '0, '0, '0);
        1: load_regs('1, '1, Q_MAX, Q_MIN, Q_MAX, Q_MIN);
        // plausible tracker tuning
        2: load_regs($urandom_range(0, 1 << 16), $urandom_range(1 << 12, 1 << 18),
                     32'sd65536 << $urandom_range(0, 4), $urandom_range(0, 4096),
                     $urandom_range(0, 4096), 32'sd65536 << $urandom_range(0, 4));
        3: load_regs($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                     $urandom());
        default: load_regs('0, '0, Q_MIN, 32'sd0, Q_MAX, Q_MIN);
      endcase
      if (ph < 2) directed_items();
      // track runs: an init now and then, mostly updates
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        m.cmd = ($urandom_range(0, 11) == 0) ? CMD_INIT : CMD_UPDATE;
        m.px = rnd_val(); m.py = rnd_val(); m.pz = rnd_val();
        m.vx = rnd_val(); m.vy = rnd_val(); m.vz = rnd_val();
        m.dt = rnd_dt();
        send_item(m);
      end
      drain();
    end

    $display("Ran %0d phases: %0d inits, %0d updates (%0d with zero variance)",
             NUM_PHASES, sb.n_init, sb.n_update, sb.n_zero_var);
    $display("Checked %0d estimates, %0d field errors", sb.matched, sb.errors);
    if (sb.errors == 0 && sb.est_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
